@@ rtl/robin_hood_hash_table_macros.svh @@
`ifndef ROBIN_HOOD_HASH_TABLE_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_MACROS_SVH

// checked only outside reset
`define RHHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge
`define RHHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rhht_pkg.sv @@
package rhht_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_DISPATCH,
    S_WALK_RD,
    S_WALK_CHK,
    S_SH_RD,
    S_SH_CHK,
    S_SH_END,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    clr_write;
    logic    load;
    logic    mod_step;
    logic    walk_init;
    logic    rd;
    logic    advance;
    logic    ins_write;
    logic    ins_swap;
    logic    take_value;
    logic    shift_init;
    logic    shift_move;
    logic    shift_end;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    status_t res_status;
    logic    res_with_value;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       mod_done;
    logic       full;
    logic [1:0] op;
    logic       slot_valid;
    logic       key_match;
    logic       dist_gt_probe;
    logic       cp_gt_probe;
    logic       probe_zero;
    logic       n_last;
    logic       out_busy;
  } dp_stat_t;

endpackage

@@ rtl/robin_hood_hash_table.sv @@
// flow: a request is loaded, its hash reduced to a home slot and the op dispatched; each
// slot probed is read, then checked; a remove then shifts later entries back one by one,
// each read then checked, and clears the slot ending the shift; a full insert probes none
// throughput: one transaction at a time, the next taken in the cycle the result shows;
// reset: synchronous; a clearing pass then writes every slot empty, during which input
// is stalled; load_limit resets to 256
module robin_hood_hash_table #(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [31:0] key,
  input  logic [31:0] key_hash,
  input  logic [31:0] value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] value_out,
  output logic [8:0]  entries_used
);
  import rhht_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  rhht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  rhht_dp #(.SLOTS(SLOTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .command      (command),
    .key          (key),
    .key_hash     (key_hash),
    .value_in     (value_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .value_out    (value_out),
    .entries_used (entries_used)
  );

endmodule

@@ rtl/rhht_ctrl.sv @@
module rhht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rhht_pkg::dp_stat_t  st,
  output rhht_pkg::ctrl_cmd_t cmd
);
  import rhht_pkg::*;

  state_t  state, state_next;
  status_t res_code, res_code_next;
  logic    res_val, res_val_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      res_code <= ST_OK;
      res_val  <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      res_val  <= res_val_next;
    end
  end

  always_comb begin
    state_next         = state;
    res_code_next      = res_code;
    res_val_next       = res_val;
    cmd                = '0;
    cmd.res_status     = res_code;
    cmd.res_with_value = res_val;
    in_stall           = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.mod_step = 1'b1;
        if (st.mod_done) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        res_val_next = 1'b0;
        if (st.op == CMD_INSERT && st.full) begin
          res_code_next = ST_FULL;
          state_next    = S_RESP;
        end else if (st.op == CMD_INSERT || st.op == CMD_FIND || st.op == CMD_REMOVE) begin
          cmd.walk_init = 1'b1;
          state_next    = S_WALK_RD;
        end else begin
          res_code_next = ST_NOT_FOUND;
          state_next    = S_RESP;
        end
      end
      S_WALK_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (st.op == CMD_INSERT) begin
          if (!st.slot_valid) begin
            cmd.ins_write = 1'b1;
            cmd.cnt_inc   = 1'b1;
            res_code_next = ST_OK;
            state_next    = S_RESP;
          end else begin
            if (st.cp_gt_probe) begin
              cmd.ins_write = 1'b1;
              cmd.ins_swap  = 1'b1;
            end
            cmd.advance = 1'b1;
            state_next  = S_WALK_RD;
          end
        end else if (!st.slot_valid || st.dist_gt_probe) begin
          res_code_next = ST_NOT_FOUND;
          state_next    = S_RESP;
        end else if (st.key_match) begin
          cmd.take_value = 1'b1;
          res_code_next  = ST_OK;
          res_val_next   = 1'b1;
          if (st.op == CMD_REMOVE) begin
            cmd.shift_init = 1'b1;
            cmd.cnt_dec    = 1'b1;
            state_next     = S_SH_RD;
          end else begin
            state_next = S_RESP;
          end
        end else if (st.n_last) begin
          res_code_next = ST_NOT_FOUND;
          state_next    = S_RESP;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_WALK_RD;
        end
      end
      S_SH_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_SH_CHK;
      end
      S_SH_CHK: begin
        if (!st.slot_valid || st.probe_zero) begin
          cmd.shift_end = 1'b1;
          state_next    = S_RESP;
        end else begin
          cmd.shift_move = 1'b1;
          state_next     = st.n_last ? S_SH_END : S_SH_RD;
        end
      end
      S_SH_END: begin
        cmd.shift_end = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        if (!st.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

@@ rtl/rhht_dp.sv @@
module rhht_dp #(
  parameter int SLOTS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  rhht_pkg::ctrl_cmd_t cmd,
  output rhht_pkg::dp_stat_t  st,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_wdata,
  input  logic [1:0]          command,
  input  logic [31:0]         key,
  input  logic [31:0]         key_hash,
  input  logic [31:0]         value_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [31:0]         value_out,
  output logic [8:0]          entries_used
);
  import rhht_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = SW + 1;
  localparam int LW = (CW > 9) ? CW : 9;
  localparam int MW = 65 + SW;

  logic [MW-1:0] mem [SLOTS];
  logic [MW-1:0] rd_data;
  logic          we;
  logic [SW-1:0] wa;
  logic [MW-1:0] wd;

  logic [8:0]    load_limit;
  logic [CW-1:0] cnt;
  logic [SW-1:0] clr_addr;

  logic [1:0]    op;
  logic [31:0]   key_q, value_q, found_val;
  logic [31:0]   hash_sr;
  logic [CW-1:0] rem, rem_next;
  logic [2:0]    mod_cnt;

  logic [SW-1:0] s, s_inc, prev, walk_len, cp;
  logic [31:0]   ck, cv;

  logic          rd_valid;
  logic [SW-1:0] rd_probe;
  logic [31:0]   rd_key, rd_value;

  assign rd_valid = rd_data[MW-1];
  assign rd_probe = rd_data[64 +: SW];
  assign rd_key   = rd_data[63:32];
  assign rd_value = rd_data[31:0];
  assign s_inc    = (s == SW'(SLOTS - 1)) ? '0 : s + 1'b1;

  // four hash bits folded into the remainder per step
  always_comb begin
    rem_next = rem;
    for (int i = 0; i < 4; i++) begin
      rem_next = {rem_next[SW-1:0], hash_sr[31-i]};
      if (rem_next >= CW'(SLOTS)) rem_next = rem_next - CW'(SLOTS);
    end
  end

  always_comb begin
    we = 1'b0;
    wa = s;
    wd = {1'b1, cp, ck, cv};
    priority if (cmd.clr_write) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '0;
    end else if (cmd.ins_write) begin
      we = 1'b1;
    end else if (cmd.shift_move) begin
      we = 1'b1;
      wa = prev;
      wd = {1'b1, rd_probe - 1'b1, rd_key, rd_value};
    end else if (cmd.shift_end) begin
      we = 1'b1;
      wa = prev;
      wd = '0;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd) rd_data <= mem[s];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= 9'd256;
      cnt        <= '0;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) load_limit <= cfg_wdata;
      if (cmd.clr_write) clr_addr <= clr_addr + 1'b1;
      if (cmd.cnt_inc) cnt <= cnt + 1'b1;
      else if (cmd.cnt_dec && cnt != '0) cnt <= cnt - 1'b1;
      if (cmd.res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= command;
      key_q   <= key;
      value_q <= value_in;
      hash_sr <= key_hash;
      rem     <= '0;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      hash_sr <= hash_sr << 4;
      rem     <= rem_next;
      mod_cnt <= mod_cnt + 1'b1;
    end
    if (cmd.walk_init) begin
      s        <= rem[SW-1:0];
      walk_len <= '0;
      cp       <= '0;
      ck       <= key_q;
      cv       <= value_q;
    end else if (cmd.advance) begin
      s        <= s_inc;
      walk_len <= walk_len + 1'b1;
      cp       <= cp + 1'b1;
      if (cmd.ins_swap) begin
        ck <= rd_key;
        cv <= rd_value;
        cp <= rd_probe + 1'b1;
      end
    end else if (cmd.shift_init) begin
      prev     <= s;
      s        <= s_inc;
      walk_len <= '0;
    end else if (cmd.shift_move) begin
      prev     <= s;
      s        <= s_inc;
      walk_len <= walk_len + 1'b1;
    end
    if (cmd.take_value) found_val <= rd_value;
    if (cmd.res_load) begin
      status       <= cmd.res_status;
      value_out    <= cmd.res_with_value ? found_val : 32'd0;
      entries_used <= 9'(cnt);
    end
  end

  always_comb begin
    st               = '0;
    st.clr_last      = (clr_addr == SW'(SLOTS - 1));
    st.mod_done      = (mod_cnt == 3'd7);
    st.full          = (LW'(cnt) >= LW'(load_limit)) || (cnt >= CW'(SLOTS));
    st.op            = op;
    st.slot_valid    = rd_valid;
    st.key_match     = (rd_key == key_q);
    st.dist_gt_probe = (walk_len > rd_probe);
    st.cp_gt_probe   = (cp > rd_probe);
    st.probe_zero    = (rd_probe == '0);
    st.n_last        = (walk_len == SW'(SLOTS - 1));
    st.out_busy      = out_valid && out_stall;
  end

endmodule

@@ rtl/rhht_checker.sv @@
`include "robin_hood_hash_table_macros.svh"

module rhht_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [31:0] value_out
);
  import rhht_pkg::*;

  `RHHT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `RHHT_ASSERT(a_status_code, out_valid |-> status != 2'd3, "undefined status code")
  `RHHT_ASSERT(a_miss_zero, out_valid && (status == ST_NOT_FOUND || status == ST_FULL) |-> value_out == 32'd0, "value on a miss")
  `RHHT_ASSERT_ALWAYS(a_clear_stall, $past(rst) && !rst |-> in_stall, "input taken during clearing")

endmodule

bind robin_hood_hash_table rhht_checker u_rhht_checker (.*);

@@ verif/tb_robin_hood_hash_table.sv @@
module tb_robin_hood_hash_table;
  import rhht_pkg::*;

  localparam int NSLOT = 256;
  localparam int WATCHDOG = 40000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_FIND;
  logic [31:0] key = '0;
  logic [31:0] key_hash = '0;
  logic [31:0] value_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [8:0]  entries_used;

  robin_hood_hash_table uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .key(key),
    .key_hash(key_hash), .value_in(value_in), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .value_out(value_out),
    .entries_used(entries_used)
  );

  always #10 clk = ~clk;

  typedef struct {
    status_t     st;
    logic [31:0] val;
    logic [8:0]  used;
  } reply_t;

  reply_t replies_due[$];

  // table shadow
  bit          sh_valid[NSLOT];
  logic [31:0] sh_key[NSLOT];
  logic [31:0] sh_val[NSLOT];
  int          sh_dist[NSLOT];
  int          sh_count;
  int          sh_limit;

  int  errors = 0;
  int  sent = 0;
  int  checked = 0;
  int  idle_cycles = 0;
  int  n_full = 0;
  int  n_miss = 0;
  bit  quiet = 1'b0;
  int  ostall_left = 0;
  logic [31:0] pool[64];

  function automatic bit find_slot(logic [31:0] k, logic [31:0] h, output int where);
    int s;
    s = h % NSLOT;
    where = 0;
    for (int d = 0; d < NSLOT; d++) begin
      if (!sh_valid[s] || d > sh_dist[s]) return 1'b0;
      if (sh_key[s] == k) begin
        where = s;
        return 1'b1;
      end
      s = (s + 1) % NSLOT;
    end
    return 1'b0;
  endfunction

  function automatic void place_entry(logic [31:0] k, logic [31:0] h, logic [31:0] v);
    int s;
    int cp;
    int td;
    logic [31:0] ck;
    logic [31:0] cv;
    logic [31:0] t;
    s = h % NSLOT;
    ck = k;
    cv = v;
    cp = 0;
    for (int n = 0; n < NSLOT && sh_valid[s]; n++) begin
      if (cp > sh_dist[s]) begin
        t = sh_key[s]; sh_key[s] = ck; ck = t;
        t = sh_val[s]; sh_val[s] = cv; cv = t;
        td = sh_dist[s]; sh_dist[s] = cp; cp = td;
      end
      cp++;
      s = (s + 1) % NSLOT;
    end
    sh_valid[s] = 1'b1;
    sh_key[s] = ck;
    sh_val[s] = cv;
    sh_dist[s] = cp;
  endfunction

  function automatic void close_gap(int hole);
    int prev;
    int s;
    prev = hole;
    s = (hole + 1) % NSLOT;
    for (int n = 0; n < NSLOT; n++) begin
      if (!sh_valid[s] || sh_dist[s] == 0) break;
      sh_key[prev] = sh_key[s];
      sh_val[prev] = sh_val[s];
      sh_dist[prev] = sh_dist[s] - 1;
      sh_valid[prev] = 1'b1;
      prev = s;
      s = (s + 1) % NSLOT;
    end
    sh_valid[prev] = 1'b0;
  endfunction

  function automatic reply_t table_op(op_t op, logic [31:0] k, logic [31:0] h,
                                      logic [31:0] v);
    reply_t r;
    int where;
    r.st = ST_NOT_FOUND;
    r.val = '0;
    case (op)
      CMD_INSERT: begin
        if (sh_count >= sh_limit || sh_count >= NSLOT) begin
          r.st = ST_FULL;
        end else begin
          place_entry(k, h, v);
          sh_count++;
          r.st = ST_OK;
        end
      end
      CMD_FIND: begin
        if (find_slot(k, h, where)) begin
          r.st = ST_OK;
          r.val = sh_val[where];
        end
      end
      CMD_REMOVE: begin
        if (find_slot(k, h, where)) begin
          r.st = ST_OK;
          r.val = sh_val[where];
          close_gap(where);
          if (sh_count > 0) sh_count--;
        end
      end
      default: ;
    endcase
    r.used = sh_count[8:0];
    if (r.st == ST_FULL) n_full++;
    if (r.st == ST_NOT_FOUND) n_miss++;
    return r;
  endfunction

  // clustered home slots so probe runs get long
  function automatic logic [31:0] hash_for(logic [31:0] k);
    logic [31:0] p;
    p = k * 32'h9E3779B1;
    return {p[31:8], 3'b000, p[12:8]};
  endfunction

  task automatic send_op(op_t op, logic [31:0] k, logic [31:0] h, logic [31:0] v);
    int gap;
    if (!quiet && $urandom_range(5) == 0) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= op;
    key <= k;
    key_hash <= h;
    value_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    replies_due.push_back(table_op(op, k, h, v));
    sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_load_limit(int lim);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= lim[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_limit = lim;
  endtask

  // result checking
  always @(posedge clk) begin
    reply_t e;
    if (!rst && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        $display("%0t unexpected transaction: status %0d value %h used %0d",
                 $time, status, value_out, entries_used);
        errors++;
      end else begin
        e = replies_due.pop_front();
        checked++;
        if (status !== e.st) begin
          $display("%0t status: expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        if (value_out !== e.val) begin
          $display("%0t value_out: expected %h actual %h", $time, e.val, value_out);
          errors++;
        end
        if (entries_used !== e.used) begin
          $display("%0t entries_used: expected %0d actual %0d", $time, e.used,
                   entries_used);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (ostall_left > 0) begin
      ostall_left <= ostall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(5) == 0) begin
      ostall_left <= $urandom_range(3, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed;
    logic [31:0] h;
    h = 32'h0000_0005;
    send_op(CMD_INSERT, 32'h0, 32'h0, 32'h0);
    send_op(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(CMD_FIND, 32'h0, 32'h0, 32'h0);
    send_op(CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_op(CMD_FIND, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF);
    send_op(CMD_REMOVE, 32'h1234_5678, 32'h0, 32'h0);
    // run sharing one home slot, plus wrap past the last slot
    for (int i = 0; i < 5; i++) send_op(CMD_INSERT, 32'h100 + i, h, 32'hA0 + i);
    send_op(CMD_INSERT, 32'h200, 32'h0000_0006, 32'hB0);
    send_op(CMD_REMOVE, 32'h101, h, 32'h0);
    send_op(CMD_FIND, 32'h104, h, 32'h0);
    send_op(CMD_FIND, 32'h200, 32'h0000_0006, 32'h0);
    send_op(CMD_INSERT, 32'h300, 32'h0000_00FF, 32'hC0);
    send_op(CMD_INSERT, 32'h301, 32'h0000_01FF, 32'hC1);
    send_op(CMD_FIND, 32'h301, 32'h0000_01FF, 32'h0);
    send_op(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    // duplicate key stores a second entry
    send_op(CMD_INSERT, 32'h400, 32'h40, 32'h1);
    send_op(CMD_INSERT, 32'h400, 32'h40, 32'h2);
    send_op(CMD_REMOVE, 32'h400, 32'h40, 32'h0);
    send_op(CMD_FIND, 32'h400, 32'h40, 32'h0);
    send_op(CMD_FIND, 32'h300, 32'h0000_00FF, 32'h0);
  endtask

  task automatic test_load_limit;
    set_load_limit(0);
    send_op(CMD_INSERT, 32'h500, 32'h50, 32'h5);
    send_op(CMD_FIND, 32'h0, 32'h0, 32'h0);
    set_load_limit(sh_count + 2);
    for (int i = 0; i < 4; i++) send_op(CMD_INSERT, 32'h600 + i, 32'h60, i);
    set_load_limit(NSLOT);
  endtask

  task automatic test_fill_and_empty;
    logic [31:0] fk[NSLOT];
    logic [31:0] fh[NSLOT];
    int nf;
    nf = 0;
    while (sh_count < NSLOT) begin
      fk[nf] = 32'h8000_0000 + nf;
      fh[nf] = $urandom;
      send_op(CMD_INSERT, fk[nf], fh[nf], $urandom);
      nf++;
    end
    send_op(CMD_INSERT, 32'h7777, 32'h77, 32'h7);
    send_op(CMD_FIND, fk[nf - 1], fh[nf - 1], 32'h0);
    send_op(CMD_FIND, 32'h7777, 32'h77, 32'h0);
    for (int i = 0; i < nf; i++) send_op(CMD_REMOVE, fk[i], fh[i], 32'h0);
    // clear out what the directed and load limit parts left behind
    for (int s = 0; s < NSLOT; s++)
      while (sh_valid[s]) send_op(CMD_REMOVE, sh_key[s], 32'(s - sh_dist[s]), 32'h0);
  endtask

  task automatic test_random(int n, int lim);
    int pick;
    int r;
    logic [31:0] k;
    logic [31:0] h;
    set_load_limit(lim);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      pick = $urandom_range(63);
      k = pool[pick];
      h = hash_for(k);
      if ($urandom_range(9) == 0) begin
        k = $urandom;
        h = $urandom;
      end
      if (r < 45) send_op(CMD_INSERT, k, h, $urandom);
      else if (r < 75) send_op(CMD_FIND, k, h, $urandom);
      else send_op(CMD_REMOVE, k, h, $urandom);
    end
  endtask

  initial begin
    int wait_cycles;
    for (int s = 0; s < NSLOT; s++) begin
      sh_valid[s] = 1'b0;
      sh_dist[s] = 0;
    end
    sh_count = 0;
    sh_limit = 256;
    for (int i = 0; i < 64; i++) pool[i] = $urandom;
    pool[0] = 32'h0;
    pool[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_load_limit();
    test_fill_and_empty();
    test_random(300, 256);
    test_random(300, 40);
    test_random(300, 200);
    quiet = 1'b1;
    test_random(200, 256);

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (replies_due.size() != 0 && wait_cycles < WATCHDOG) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    $display("ran %0d operations, %0d results checked (%0d full, %0d not found)",
             sent, checked, n_full, n_miss);
    $display("covered clustered runs, wrap-around, full table and load limits 0 to 256");
    if (errors == 0 && replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rhht_pkg.sv
rtl/rhht_ctrl.sv
rtl/rhht_dp.sv
rtl/robin_hood_hash_table.sv
rtl/rhht_checker.sv
verif/tb_robin_hood_hash_table.sv
